>>> hdl/lbac_pkg.sv
// Shared constants and result codes of the linked block allocation checker.
`default_nettype none

package lbac_pkg;

  localparam int DEF_TOTAL_BLOCKS = 1024;
  localparam int DEF_MAX_CHAIN    = 128;

  localparam int BLOCK_W  = 10;
  localparam int FILE_W   = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_START = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_HELD     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd3;

endpackage

`default_nettype wire

>>> hdl/lbac_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module lbac_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/linked_block_allocation_check.sv
// Each block takes an accept step (with the bitmap read), then a check step; a final
// block is decided in its check step, which waits while the output is held, and the
// result is registered as that step ends. No block is taken until the last is checked,
// nor while the commit walk of an accepted file reads each stored block from the
// pending list and marks it in the bitmap. Reset: synchronous; afterwards a clearing
// pass zeroes the bitmap, one entry a cycle, and no request is taken until it ends.
`default_nettype none

module linked_block_allocation_check #(
  parameter int TOTAL_BLOCKS = lbac_pkg::DEF_TOTAL_BLOCKS,
  parameter int MAX_CHAIN    = lbac_pkg::DEF_MAX_CHAIN
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lbac_pkg::BLOCK_W-1:0]   start_block,
  input  wire logic [lbac_pkg::BLOCK_W-1:0]   block_number,
  input  wire logic                           last_block,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [lbac_pkg::FILE_W-1:0]    file_number,
  output logic      [lbac_pkg::STATUS_W-1:0]  status,
  output logic      [lbac_pkg::COUNT_W-1:0]   block_count
);

  localparam int AW = $clog2(TOTAL_BLOCKS);
  localparam int IW = $clog2(MAX_CHAIN);
  localparam int CW = $clog2(MAX_CHAIN + 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_CRD   = 5'b01000,
    ST_CWR   = 5'b10000
  } state_t;

  state_t state;

  logic [AW-1:0]                  clr_idx;
  logic [lbac_pkg::BLOCK_W-1:0]   blk;
  logic                           last;
  logic [CW-1:0]                  pending_count;
  logic                           start_seen;
  logic                           overlap_seen;
  logic                           overflow_seen;
  logic [lbac_pkg::FILE_W-1:0]    file_counter;
  logic [CW-1:0]                  commit_count;
  logic [CW-1:0]                  commit_idx;

  logic                           accept;
  logic                           held_rd;
  logic [lbac_pkg::BLOCK_W-1:0]   pend_rd;
  logic                           held_wr_en;
  logic [AW-1:0]                  held_wr_addr;
  logic                           pend_wr_en;
  logic                           blk_out_of_range;
  logic                           pend_in_range;
  logic                           overlap_now;
  logic [lbac_pkg::STATUS_W-1:0]  status_next;
  logic                           can_emit;
  logic                           emit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign blk_out_of_range = 32'(blk) >= 32'(TOTAL_BLOCKS);
  assign pend_in_range    = 32'(pend_rd) < 32'(TOTAL_BLOCKS);
  assign overlap_now      = overlap_seen || held_rd || blk_out_of_range;
  assign can_emit         = !out_valid || out_ready;
  assign emit             = (state == ST_CHECK) && last && can_emit;

  always_comb begin
    if (!start_seen) begin
      status_next = lbac_pkg::STATUS_NO_START;
    end else if (overlap_now) begin
      status_next = lbac_pkg::STATUS_HELD;
    end else if (overflow_seen) begin
      status_next = lbac_pkg::STATUS_TOO_LONG;
    end else begin
      status_next = lbac_pkg::STATUS_OK;
    end
  end

  // The bitmap's single write port serves the clearing pass and the commit walk.
  assign held_wr_en   = (state == ST_CLEAR) || ((state == ST_CWR) && pend_in_range);
  assign held_wr_addr = (state == ST_CLEAR) ? clr_idx : AW'(pend_rd);

  lbac_ram #(
    .WIDTH(1),
    .DEPTH(TOTAL_BLOCKS)
  ) u_held_map (
    .clk     (clk),
    .wr_en   (held_wr_en),
    .wr_addr (held_wr_addr),
    .wr_data (state != ST_CLEAR),
    .rd_en   (accept),
    .rd_addr (AW'(block_number)),
    .rd_data (held_rd)
  );

  assign pend_wr_en = accept && (32'(pending_count) < 32'(MAX_CHAIN));

  lbac_ram #(
    .WIDTH(lbac_pkg::BLOCK_W),
    .DEPTH(MAX_CHAIN)
  ) u_pending_list (
    .clk     (clk),
    .wr_en   (pend_wr_en),
    .wr_addr (pending_count[IW-1:0]),
    .wr_data (block_number),
    .rd_en   (state == ST_CRD),
    .rd_addr (commit_idx[IW-1:0]),
    .rd_data (pend_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      pending_count <= '0;
      start_seen    <= 1'b0;
      overlap_seen  <= 1'b0;
      overflow_seen <= 1'b0;
      file_counter  <= '0;
      commit_idx    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(TOTAL_BLOCKS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            blk  <= block_number;
            last <= last_block;
            if (block_number == start_block) begin
              start_seen <= 1'b1;
            end
            if (pend_wr_en) begin
              pending_count <= pending_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!last) begin
            overlap_seen <= overlap_now;
            state        <= ST_IDLE;
          end else if (can_emit) begin
            file_number   <= file_counter;
            status        <= status_next;
            block_count   <= lbac_pkg::COUNT_W'(pending_count);
            file_counter  <= file_counter + 1'b1;
            commit_count  <= pending_count;
            commit_idx    <= '0;
            pending_count <= '0;
            start_seen    <= 1'b0;
            overlap_seen  <= 1'b0;
            overflow_seen <= 1'b0;
            state <= (status_next == lbac_pkg::STATUS_OK) ? ST_CRD : ST_IDLE;
          end
        end
        ST_CRD: begin
          state <= ST_CWR;
        end
        ST_CWR: begin
          commit_idx <= commit_idx + 1'b1;
          if (commit_idx + 1'b1 == commit_count) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_CRD;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CHECK)
    else $error("accepted request not followed by its check cycle");

  a_counter_tracks_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> file_counter == lbac_pkg::FILE_W'(file_number + 1'b1))
    else $error("file counter out of step with the emitted result");

  a_commit_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRD && $past(state) == ST_CHECK) |->
      (out_valid && status == lbac_pkg::STATUS_OK))
    else $error("commit walk started for a rejected file");

  a_commit_index_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CWR |-> commit_idx < commit_count)
    else $error("commit walk ran past the pending list");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the linked block allocation checker.
`timescale 1ns / 100ps

module tb;

  localparam int NUM_BLOCKS = lbac_pkg::DEF_TOTAL_BLOCKS;
  localparam int CHAIN_CAP  = lbac_pkg::DEF_MAX_CHAIN;

  typedef struct packed {
    logic [lbac_pkg::FILE_W-1:0]   file_no;
    logic [lbac_pkg::STATUS_W-1:0] status;
    logic [lbac_pkg::COUNT_W-1:0]  count;
  } file_verdict_t;

  typedef struct packed {
    logic [lbac_pkg::BLOCK_W-1:0]  start;
    logic [lbac_pkg::BLOCK_W-1:0]  first;
    logic [lbac_pkg::BLOCK_W-1:0]  stride;
    logic [7:0]                    length;
    bit                            typed;
    logic [lbac_pkg::STATUS_W-1:0] status;
    logic [lbac_pkg::COUNT_W-1:0]  count;
  } file_plan_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [lbac_pkg::BLOCK_W-1:0] start_block;
  logic [lbac_pkg::BLOCK_W-1:0] block_number;
  logic last_block;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [lbac_pkg::FILE_W-1:0] file_number;
  logic [lbac_pkg::STATUS_W-1:0] status;
  logic [lbac_pkg::COUNT_W-1:0] block_count;

  // Shadow copy of the allocation state.
  bit                           held_blocks [NUM_BLOCKS];
  logic [lbac_pkg::BLOCK_W-1:0] chain_store [CHAIN_CAP];
  int                           chain_len = 0;
  bit                           saw_start = 1'b0;
  bit                           saw_held = 1'b0;
  bit                           saw_overflow = 1'b0;
  logic [lbac_pkg::FILE_W-1:0]  next_file = '0;

  bit            in_chain [NUM_BLOCKS];
  file_verdict_t pending_verdicts [$];
  int            sender_idle_pct = 14;
  int            receiver_idle_pct = 68;
  int            fail_count = 0;

  // Each row is one file; the block chain is first, first + stride, ...
  file_plan_t directed_files [14] = '{
    '{10'd5,    10'd5,    10'd1,   8'd1,   1'b1, lbac_pkg::STATUS_OK,       8'd1},
    '{10'd7,    10'd8,    10'd1,   8'd2,   1'b1, lbac_pkg::STATUS_NO_START, 8'd2},
    '{10'd5,    10'd5,    10'd1,   8'd1,   1'b1, lbac_pkg::STATUS_HELD,     8'd1},
    '{10'd1023, 10'd1023, 10'd1,   8'd1,   1'b1, lbac_pkg::STATUS_OK,       8'd1},
    '{10'd0,    10'd0,    10'd1,   8'd1,   1'b1, lbac_pkg::STATUS_OK,       8'd1},
    '{10'd100,  10'd5,    10'd1,   8'd1,   1'b1, lbac_pkg::STATUS_NO_START, 8'd1},
    '{10'd200,  10'd200,  10'd0,   8'd2,   1'b1, lbac_pkg::STATUS_OK,       8'd2},
    '{10'd300,  10'd300,  10'd1,   8'd129, 1'b1, lbac_pkg::STATUS_TOO_LONG, 8'd128},
    '{10'd894,  10'd894,  10'd1,   8'd130, 1'b1, lbac_pkg::STATUS_HELD,     8'd128},
    '{10'd428,  10'd300,  10'd1,   8'd129, 1'b1, lbac_pkg::STATUS_TOO_LONG, 8'd128},
    '{10'd500,  10'd500,  10'd1,   8'd128, 1'b1, lbac_pkg::STATUS_OK,       8'd128},
    '{10'd682,  10'd341,  10'd341, 8'd3,   1'b0, lbac_pkg::STATUS_OK,       8'd0},
    '{10'd341,  10'd341,  10'd1,   8'd1,   1'b0, lbac_pkg::STATUS_OK,       8'd0},
    '{10'd682,  10'd682,  10'd1,   8'd1,   1'b0, lbac_pkg::STATUS_OK,       8'd0}
  };

  linked_block_allocation_check dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_block  (start_block),
    .block_number (block_number),
    .last_block   (last_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .file_number  (file_number),
    .status       (status),
    .block_count  (block_count)
  );

  always #6 clk = ~clk;

  // Updates the shadow state with one block and returns 1 when a file is decided.
  function automatic bit predict_verdict(input logic [lbac_pkg::BLOCK_W-1:0] sb,
                                         input logic [lbac_pkg::BLOCK_W-1:0] blk,
                                         input bit last,
                                         output file_verdict_t v);
    logic [lbac_pkg::STATUS_W-1:0] st;
    v = '0;
    if (blk == sb) saw_start = 1'b1;
    if (int'(blk) >= NUM_BLOCKS || held_blocks[blk]) saw_held = 1'b1;
    if (chain_len < CHAIN_CAP) begin
      chain_store[chain_len] = blk;
      chain_len++;
    end else begin
      saw_overflow = 1'b1;
    end
    if (!last) return 1'b0;
    if (!saw_start) st = lbac_pkg::STATUS_NO_START;
    else if (saw_held) st = lbac_pkg::STATUS_HELD;
    else if (saw_overflow) st = lbac_pkg::STATUS_TOO_LONG;
    else st = lbac_pkg::STATUS_OK;
    if (st == lbac_pkg::STATUS_OK) begin
      for (int i = 0; i < chain_len; i++) held_blocks[chain_store[i]] = 1'b1;
    end
    v.file_no = next_file;
    v.status  = st;
    v.count   = lbac_pkg::COUNT_W'(chain_len);
    next_file++;
    chain_len = 0;
    saw_start = 1'b0;
    saw_held = 1'b0;
    saw_overflow = 1'b0;
    return 1'b1;
  endfunction

  // Picks a block neither held nor already in the chain being built, if one is found.
  function automatic logic [lbac_pkg::BLOCK_W-1:0] pick_free();
    logic [lbac_pkg::BLOCK_W-1:0] b;
    for (int t = 0; t < 32; t++) begin
      b = lbac_pkg::BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
      if (!held_blocks[b] && !in_chain[b]) begin
        in_chain[b] = 1'b1;
        return b;
      end
    end
    return lbac_pkg::BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
  endfunction

  function automatic logic [lbac_pkg::BLOCK_W-1:0] pick_held();
    logic [lbac_pkg::BLOCK_W-1:0] b;
    for (int t = 0; t < 64; t++) begin
      b = lbac_pkg::BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
      if (held_blocks[b]) return b;
    end
    return lbac_pkg::BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
  endfunction

  // Called at a falling edge; returns at the falling edge after the last request.
  task automatic send_file(input logic [lbac_pkg::BLOCK_W-1:0] sb,
                           input logic [lbac_pkg::BLOCK_W-1:0] chain[$],
                           input bit typed, input file_verdict_t typed_v);
    file_verdict_t v;
    foreach (chain[i]) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid     <= 1'b1;
      start_block  <= sb;
      block_number <= chain[i];
      last_block   <= (i == chain.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      if (predict_verdict(sb, chain[i], i == chain.size() - 1, v))
        pending_verdicts.push_back(typed ? typed_v : v);
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= receiver_idle_pct);

  always @(posedge clk) begin : check_result
    file_verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: file_number %0d status %0d block_count %0d",
               file_number, status, block_count);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (file_number !== want.file_no) begin
          $error("file_number: expected %0d, actual %0d", want.file_no, file_number);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
        if (block_count !== want.count) begin
          $error("block_count: expected %0d, actual %0d", want.count, block_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [lbac_pkg::BLOCK_W-1:0] chain [$];
    logic [lbac_pkg::BLOCK_W-1:0] sb;
    file_verdict_t                typed_v;
    int kind;
    int len;
    int random_items;
    int phase;

    random_items = 0;
    phase = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    start_block = '0;
    block_number = '0;
    last_block = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_files[r]) begin
      chain.delete();
      for (int k = 0; k < directed_files[r].length; k++)
        chain.push_back(lbac_pkg::BLOCK_W'(directed_files[r].first
                                           + k * directed_files[r].stride));
      typed_v.file_no = lbac_pkg::FILE_W'(r);
      typed_v.status  = directed_files[r].status;
      typed_v.count   = directed_files[r].count;
      send_file(directed_files[r].start, chain, directed_files[r].typed, typed_v);
    end
    drain();

    // The directed rows carry about 530 requests; the random part makes up the rest.
    while (random_items < 1170) begin
      if (phase == 0 && random_items >= 390) begin
        drain();
        sender_idle_pct = 68;
        receiver_idle_pct = 14;
        phase = 1;
      end else if (phase == 1 && random_items >= 780) begin
        drain();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        phase = 2;
      end
      chain.delete();
      kind = $urandom_range(199);
      len = (kind == 0) ? $urandom_range(126, 131) : $urandom_range(1, 3);
      if (kind < 170) begin
        for (int i = 0; i < len; i++) chain.push_back(pick_free());
        foreach (chain[i]) in_chain[chain[i]] = 1'b0;
        sb = chain[0];
        if (kind == 0 || (kind >= 100 && kind < 120)) begin
          // Start block somewhere along the chain, which for long files may lie beyond capacity.
          sb = chain[$urandom_range(len - 1)];
        end else if (kind >= 120 && kind < 140) begin
          sb = lbac_pkg::BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
        end else if (kind >= 140 && kind < 160) begin
          chain[$urandom_range(len - 1)] = pick_held();
        end else if (kind >= 160) begin
          chain.push_back(chain[$urandom_range(len - 1)]);
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          chain.push_back(lbac_pkg::BLOCK_W'($urandom_range(NUM_BLOCKS - 1)));
        sb = $urandom_range(1) ? chain[0]
                               : lbac_pkg::BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
      end
      send_file(sb, chain, 1'b0, '0);
      random_items += chain.size();
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lbac_pkg.sv
hdl/lbac_ram.sv
hdl/linked_block_allocation_check.sv
tb/tb.sv
